// ===== hdl/pngrf_pkg.sv =====
// pngrf_pkg: shared types and constants for the png row filter unit
// no dependencies; used by the top level and the port checker

package pngrf_pkg;

    localparam int unsigned LINE_W     = 13;
    localparam int unsigned BPP_W      = 4;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned TYPE_W     = 3;
    localparam int unsigned SCORE_W    = 20;
    localparam int unsigned NUM_TYPES  = 5;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
    localparam logic [7:0]         FOLD_LIMIT  = 8'd128;
    localparam logic [7:0]         BYTE_MAX    = 8'd255;
    localparam logic [TYPE_W-1:0]  LAST_TYPE   = 3'd4;

    localparam logic [LINE_W-1:0]  LINE_BYTES_RST = 13'd1;
    localparam logic [BPP_W-1:0]   BPP_RST        = 4'd1;
    localparam logic [MODE_W-1:0]  MODE_MIN_SUM   = 3'd5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD      = 2'd0,
        ACT_READ      = 2'd1,
        ACT_NEW_IMAGE = 2'd2
    } action_t;

    typedef enum logic [TYPE_W-1:0] {
        FT_NONE  = 3'd0,
        FT_SUB   = 3'd1,
        FT_UP    = 3'd2,
        FT_AVG   = 3'd3,
        FT_PAETH = 3'd4
    } ftype_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINE_BYTES  = 2'd0,
        REG_BPP         = 2'd1,
        REG_FILTER_MODE = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_EVAL,
        ST_SELECT
    } state_t;

endpackage

// ===== hdl/pngrf_ram.sv =====
// pngrf_ram: generic single-clock ram, one write port and one registered read port
// no dependencies; holds one bank of scanline bytes

module pngrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/png_row_filter_min_sum_select_unit.sv =====
// png_row_filter_min_sum_select_unit: png scanline filter with minimum-sum type choice
// depends on pngrf_pkg and pngrf_ram (two banks: current row and row above)
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  action, data_byte
// out      source     out_valid / out_stall out_byte, is_type_byte, last
// cfg      apb slave  psel/penable/pwrite  paddr, pwdata, prdata
//
// load or filtered-byte request: accept, two fetches over the two bank rams, then evaluate
// end of a loaded row in minimum-sum mode adds a score scan over the five filter types
// type byte request: accept, then evaluate; new image and ignored requests complete on acceptance
// reset sets control and config registers; row rams are not cleared, hold garbage until written
// a result waits in the output register; a read evaluation holds while that register is stalled

module png_row_filter_min_sum_select_unit #(
    parameter int MAX_LINE_BYTES  = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [pngrf_pkg::ACTION_W-1:0]        action,
    input  logic [7:0]                            data_byte,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            out_byte,
    output logic                                  is_type_byte,
    output logic                                  last,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pngrf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pngrf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pngrf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);

    // configuration
    logic [pngrf_pkg::LINE_W-1:0] line_bytes_reg;
    logic [pngrf_pkg::BPP_W-1:0]  bpp_reg;
    logic [pngrf_pkg::MODE_W-1:0] mode_reg;

    // control state
    pngrf_pkg::state_t            state_reg, state_next;
    logic                         bank_reg, bank_next;
    logic                         above_valid_reg, above_valid_next;
    logic                         row_ready_reg, row_ready_next;
    logic [ADDR_W-1:0]            load_pos_reg, load_pos_next;
    logic [POS_W-1:0]             read_pos_reg, read_pos_next;
    logic [pngrf_pkg::TYPE_W-1:0] chosen_reg, chosen_next;
    logic [pngrf_pkg::SCORE_W-1:0] score_reg [pngrf_pkg::NUM_TYPES];
    logic [pngrf_pkg::SCORE_W-1:0] score_next [pngrf_pkg::NUM_TYPES];
    logic                         is_load_reg, is_load_next;
    logic                         is_type_reg, is_type_next;
    logic [pngrf_pkg::TYPE_W-1:0] sel_t_reg, sel_t_next;
    logic [pngrf_pkg::TYPE_W-1:0] best_reg, best_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    logic [ADDR_W-1:0]            x_reg, x_next;
    logic [7:0]                   data_reg, data_next;
    logic [7:0]                   a_reg, a_next;
    logic [7:0]                   b_reg, b_next;
    logic [pngrf_pkg::SCORE_W-1:0] best_score_reg, best_score_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic                         is_type_byte_reg, is_type_byte_next;
    logic                         last_reg, last_next;

    // datapath
    logic [POS_W-1:0]             len_eff;
    logic [pngrf_pkg::BPP_W-1:0]  bpp_eff;
    logic                         left_ok;
    logic                         row_end;
    logic [ADDR_W-1:0]            back_addr;
    logic [ADDR_W-1:0]            cur_raddr, oth_raddr;
    logic [7:0]                   ram0_rdata, ram1_rdata, cur_rdata, oth_rdata;
    logic                         wr_en;
    logic                         in_acc;
    logic                         can_emit;
    logic                         cfg_wr;
    logic [7:0]                   raw, a_m, b_m, c_m, avg_pred;
    logic [7:0]                   filt [pngrf_pkg::NUM_TYPES];
    logic [7:0]                   cost [pngrf_pkg::NUM_TYPES];
    logic [pngrf_pkg::SCORE_W:0]  sum  [pngrf_pkg::NUM_TYPES];
    logic [pngrf_pkg::SCORE_W-1:0] sel_score;
    logic                         sel_take;
    logic [pngrf_pkg::TYPE_W-1:0] best_now;
    logic [pngrf_pkg::SCORE_W-1:0] best_score_now;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] sa, sb, sc, pa, pb, pc;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        pa = sb - sc;
        pb = sa - sc;
        pc = sa + sb - sc - sc;
        if (pa < 0)
        begin
            pa = -pa;
        end
        if (pb < 0)
        begin
            pb = -pb;
        end
        if (pc < 0)
        begin
            pc = -pc;
        end
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            pngrf_pkg::REG_LINE_BYTES:  prdata = pngrf_pkg::APB_DATA_W'(line_bytes_reg);
            pngrf_pkg::REG_BPP:         prdata = pngrf_pkg::APB_DATA_W'(bpp_reg);
            pngrf_pkg::REG_FILTER_MODE: prdata = pngrf_pkg::APB_DATA_W'(mode_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg <= pngrf_pkg::LINE_BYTES_RST;
            bpp_reg        <= pngrf_pkg::BPP_RST;
            mode_reg       <= pngrf_pkg::MODE_MIN_SUM;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                pngrf_pkg::REG_LINE_BYTES:  line_bytes_reg <= pwdata[pngrf_pkg::LINE_W-1:0];
                pngrf_pkg::REG_BPP:         bpp_reg        <= pwdata[pngrf_pkg::BPP_W-1:0];
                pngrf_pkg::REG_FILTER_MODE: mode_reg       <= pwdata[pngrf_pkg::MODE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // effective line length and pixel width
    always_comb
    begin
        if (line_bytes_reg == '0)
        begin
            len_eff = POS_W'(1);
        end
        else if (32'(line_bytes_reg) > 32'(MAX_LINE_BYTES))
        begin
            len_eff = POS_W'(MAX_LINE_BYTES);
        end
        else
        begin
            len_eff = POS_W'(line_bytes_reg);
        end

        if (bpp_reg == '0)
        begin
            bpp_eff = pngrf_pkg::BPP_W'(1);
        end
        else if (32'(bpp_reg) > 32'(MAX_PIXEL_BYTES))
        begin
            bpp_eff = pngrf_pkg::BPP_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp_eff = bpp_reg;
        end
    end

    assign left_ok   = 32'(x_reg) >= 32'(bpp_eff);
    assign back_addr = ADDR_W'(32'(x_reg) - 32'(bpp_eff));
    assign row_end   = (32'(x_reg) + 32'd1) >= 32'(len_eff);

    // row rams: first fetch left and above, second fetch raw and upper-left
    assign cur_raddr = (state_reg == pngrf_pkg::ST_FETCH_A) ? back_addr : x_reg;
    assign oth_raddr = (state_reg == pngrf_pkg::ST_FETCH_A) ? x_reg : back_addr;

    assign in_acc = in_valid && (state_reg == pngrf_pkg::ST_IDLE);
    assign wr_en  = in_acc && (action == pngrf_pkg::ACT_LOAD) && !row_ready_reg;

    pngrf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en && !bank_reg),
        .waddr (load_pos_reg),
        .wdata (data_byte),
        .raddr (bank_reg ? oth_raddr : cur_raddr),
        .rdata (ram0_rdata)
    );

    pngrf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en && bank_reg),
        .waddr (load_pos_reg),
        .wdata (data_byte),
        .raddr (bank_reg ? cur_raddr : oth_raddr),
        .rdata (ram1_rdata)
    );

    assign cur_rdata = bank_reg ? ram1_rdata : ram0_rdata;
    assign oth_rdata = bank_reg ? ram0_rdata : ram1_rdata;

    // five filters and their scores
    assign raw      = is_load_reg ? data_reg : cur_rdata;
    assign a_m      = left_ok ? a_reg : 8'd0;
    assign b_m      = above_valid_reg ? b_reg : 8'd0;
    assign c_m      = (above_valid_reg && left_ok) ? oth_rdata : 8'd0;
    assign avg_pred = 8'(({1'b0, a_m} + {1'b0, b_m}) >> 1);

    always_comb
    begin
        filt[pngrf_pkg::FT_NONE]  = raw;
        filt[pngrf_pkg::FT_SUB]   = raw - a_m;
        filt[pngrf_pkg::FT_UP]    = raw - b_m;
        filt[pngrf_pkg::FT_AVG]   = raw - avg_pred;
        filt[pngrf_pkg::FT_PAETH] = raw - paeth_pred(a_m, b_m, c_m);
        for (int t = 0; t < pngrf_pkg::NUM_TYPES; t++)
        begin
            if (t == int'(pngrf_pkg::FT_NONE) || filt[t] < pngrf_pkg::FOLD_LIMIT)
            begin
                cost[t] = filt[t];
            end
            else
            begin
                cost[t] = pngrf_pkg::BYTE_MAX - filt[t];
            end
            sum[t] = {1'b0, score_reg[t]} + (pngrf_pkg::SCORE_W + 1)'(cost[t]);
        end
    end

    // score scan, one type per cycle, ties keep the lower type
    assign sel_score      = score_reg[sel_t_reg];
    assign sel_take       = (sel_t_reg == pngrf_pkg::FT_NONE) || (sel_score < best_score_reg);
    assign best_now       = sel_take ? sel_t_reg : best_reg;
    assign best_score_now = sel_take ? sel_score : best_score_reg;

    assign can_emit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        bank_next         = bank_reg;
        above_valid_next  = above_valid_reg;
        row_ready_next    = row_ready_reg;
        load_pos_next     = load_pos_reg;
        read_pos_next     = read_pos_reg;
        chosen_next       = chosen_reg;
        score_next        = score_reg;
        is_load_next      = is_load_reg;
        is_type_next      = is_type_reg;
        sel_t_next        = sel_t_reg;
        best_next         = best_reg;
        out_valid_next    = out_valid_reg && out_stall;
        x_next            = x_reg;
        data_next         = data_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        best_score_next   = best_score_reg;
        out_byte_next     = out_byte_reg;
        is_type_byte_next = is_type_byte_reg;
        last_next         = last_reg;

        case (state_reg)
            pngrf_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        pngrf_pkg::ACT_LOAD:
                        begin
                            if (!row_ready_reg)
                            begin
                                x_next       = load_pos_reg;
                                data_next    = data_byte;
                                is_load_next = 1'b1;
                                is_type_next = 1'b0;
                                state_next   = pngrf_pkg::ST_FETCH_A;
                            end
                        end
                        pngrf_pkg::ACT_READ:
                        begin
                            if (row_ready_reg)
                            begin
                                is_load_next = 1'b0;
                                if (read_pos_reg == '0)
                                begin
                                    is_type_next = 1'b1;
                                    state_next   = pngrf_pkg::ST_EVAL;
                                end
                                else
                                begin
                                    is_type_next = 1'b0;
                                    x_next       = ADDR_W'(read_pos_reg - POS_W'(1));
                                    state_next   = pngrf_pkg::ST_FETCH_A;
                                end
                            end
                        end
                        pngrf_pkg::ACT_NEW_IMAGE:
                        begin
                            above_valid_next = 1'b0;
                            load_pos_next    = '0;
                            read_pos_next    = '0;
                            row_ready_next   = 1'b0;
                            for (int t = 0; t < pngrf_pkg::NUM_TYPES; t++)
                            begin
                                score_next[t] = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            pngrf_pkg::ST_FETCH_A:
            begin
                state_next = pngrf_pkg::ST_FETCH_B;
            end

            pngrf_pkg::ST_FETCH_B:
            begin
                a_next     = cur_rdata;
                b_next     = oth_rdata;
                state_next = pngrf_pkg::ST_EVAL;
            end

            pngrf_pkg::ST_EVAL:
            begin
                if (is_type_reg)
                begin
                    if (can_emit)
                    begin
                        out_valid_next    = 1'b1;
                        out_byte_next     = 8'(chosen_reg);
                        is_type_byte_next = 1'b1;
                        last_next         = 1'b0;
                        read_pos_next     = POS_W'(1);
                        state_next        = pngrf_pkg::ST_IDLE;
                    end
                end
                else if (is_load_reg)
                begin
                    for (int t = 0; t < pngrf_pkg::NUM_TYPES; t++)
                    begin
                        score_next[t] = sum[t][pngrf_pkg::SCORE_W] ? pngrf_pkg::SCORE_MAX
                                                                   : sum[t][pngrf_pkg::SCORE_W-1:0];
                    end
                    state_next = pngrf_pkg::ST_IDLE;
                    if (row_end)
                    begin
                        load_pos_next = '0;
                        read_pos_next = '0;
                        if (mode_reg >= pngrf_pkg::MODE_MIN_SUM)
                        begin
                            sel_t_next = pngrf_pkg::FT_NONE;
                            state_next = pngrf_pkg::ST_SELECT;
                        end
                        else
                        begin
                            chosen_next    = mode_reg;
                            row_ready_next = 1'b1;
                        end
                    end
                    else
                    begin
                        load_pos_next = ADDR_W'(32'(x_reg) + 32'd1);
                    end
                end
                else if (can_emit)
                begin
                    out_valid_next    = 1'b1;
                    out_byte_next     = filt[chosen_reg];
                    is_type_byte_next = 1'b0;
                    last_next         = row_end;
                    state_next        = pngrf_pkg::ST_IDLE;
                    if (row_end)
                    begin
                        row_ready_next   = 1'b0;
                        bank_next        = !bank_reg;
                        above_valid_next = 1'b1;
                        load_pos_next    = '0;
                        read_pos_next    = '0;
                        for (int t = 0; t < pngrf_pkg::NUM_TYPES; t++)
                        begin
                            score_next[t] = '0;
                        end
                    end
                    else
                    begin
                        read_pos_next = POS_W'(32'(x_reg) + 32'd2);
                    end
                end
            end

            pngrf_pkg::ST_SELECT:
            begin
                best_next       = best_now;
                best_score_next = best_score_now;
                if (sel_t_reg == pngrf_pkg::LAST_TYPE)
                begin
                    chosen_next    = best_now;
                    row_ready_next = 1'b1;
                    state_next     = pngrf_pkg::ST_IDLE;
                end
                else
                begin
                    sel_t_next = sel_t_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = pngrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pngrf_pkg::ST_IDLE;
            bank_reg        <= 1'b0;
            above_valid_reg <= 1'b0;
            row_ready_reg   <= 1'b0;
            load_pos_reg    <= '0;
            read_pos_reg    <= '0;
            chosen_reg      <= '0;
            is_load_reg     <= 1'b0;
            is_type_reg     <= 1'b0;
            sel_t_reg       <= '0;
            best_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int t = 0; t < pngrf_pkg::NUM_TYPES; t++)
            begin
                score_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            bank_reg        <= bank_next;
            above_valid_reg <= above_valid_next;
            row_ready_reg   <= row_ready_next;
            load_pos_reg    <= load_pos_next;
            read_pos_reg    <= read_pos_next;
            chosen_reg      <= chosen_next;
            is_load_reg     <= is_load_next;
            is_type_reg     <= is_type_next;
            sel_t_reg       <= sel_t_next;
            best_reg        <= best_next;
            out_valid_reg   <= out_valid_next;
            score_reg       <= score_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        data_reg         <= data_next;
        a_reg            <= a_next;
        b_reg            <= b_next;
        best_score_reg   <= best_score_next;
        out_byte_reg     <= out_byte_next;
        is_type_byte_reg <= is_type_byte_next;
        last_reg         <= last_next;
    end

    assign in_stall     = (state_reg != pngrf_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_type_byte = is_type_byte_reg;
    assign last         = last_reg;

endmodule

// ===== hdl/pngrf_checker.sv =====
// pngrf_checker: port-level checks for the png row filter unit, bound to the top level
// depends on pngrf_pkg

module pngrf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [pngrf_pkg::ACTION_W-1:0] action,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [7:0]                     out_byte,
    input logic                           is_type_byte,
    input logic                           last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
                                   && $stable(is_type_byte) && $stable(last))
        else $error("stalled result changed");

    // type byte is a legal filter type and never ends a row
    a_type_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_type_byte |-> !last && (out_byte <= 8'(pngrf_pkg::LAST_TYPE)))
        else $error("bad type byte");

    // new image request completes at once
    a_new_image: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == pngrf_pkg::ACT_NEW_IMAGE) |=> !in_stall)
        else $error("new image request did not complete in one cycle");

    // a fresh result only follows work on a request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

endmodule

bind png_row_filter_min_sum_select_unit pngrf_checker u_checker (.*);
